>>> rtl/core/multi_kernel_window_projection_core_assert.svh
// Assertion macros used by the checker file of the projection core.
`ifndef MULTI_KERNEL_WINDOW_PROJECTION_CORE_ASSERT_SVH
`define MULTI_KERNEL_WINDOW_PROJECTION_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MKWP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MKWP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/mkwp_pkg.sv
// Constants and types shared by the window projection core and its cells.
package mkwp_pkg;

  localparam int KERNEL_COUNT = 16;
  localparam int WINDOW_TAPS  = 16;

  localparam int TAP_W   = $clog2(WINDOW_TAPS);
  localparam int KSEL_W  = $clog2(KERNEL_COUNT);
  localparam int CNT_W   = $clog2(KERNEL_COUNT + 1);

  localparam int FIELD_IDX_W = 4;
  localparam int COEF_W      = 16;
  localparam int PIX_W       = 16;
  localparam int PROD_W      = COEF_W + PIX_W;
  localparam int ACC_W       = 36;
  localparam int CFG_W       = 5;

  localparam logic OP_COEF  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic                      wr;
    logic [TAP_W-1:0]          wr_tap;
    logic signed [COEF_W-1:0]  wr_coef;
    logic                      p_valid;
    logic [TAP_W-1:0]          p_tap;
    logic signed [PIX_W-1:0]   p_pixel;
    logic                      m_valid;
    logic                      m_last;
    logic                      shift;
  } cell_ctl_t;

endpackage

>>> rtl/core/multi_kernel_window_projection_core.sv
// Top level of the window projection filter bank: sequencer and row of kernel cells.
//
// Usage:
//  - Input stream s_axis_*: tuser selects the item kind. tuser = 0 writes one Q1.14 tap
//    (kernel_index, tap_index, coefficient); tuser = 1 delivers the next pixel of the
//    window in row-major order.
//  - Every pixel goes to all kernel cells at once; each cell multiplies it by its own tap
//    and adds it into its accumulator. Pixels stream one per cycle unless held off.
//  - After the last tap of a window, the sums are loaded into the cells' output stages
//    and leave on m_axis_* down the chain one per cycle while accepted, kernel 0 first;
//    tlast marks the final kernel in use (cfg kernel_count, 0 acts as 1, above the bank
//    size acts as the bank size).
//  - The first sum becomes valid once the last pixel has passed the pixel stage, the
//    product register and the accumulate step. The input is held off while the window
//    completes and the sums drain.
//  - A stalled receiver simply freezes the chain; nothing is lost.
//  - Reset (rst, synchronous) clears the accumulators, the tap position and kernel_count
//    to the bank size. The tap store is not cleared and must be written before use.
//  - Write kernel_count via cfg_we/cfg_wdata only while idle; not enforced by the block.
module multi_kernel_window_projection_core
  import mkwp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [3:0] kernel_index, [7:4] tap_index, [23:8] coefficient, [39:24] pixel
  input  logic [39:0]       s_axis_tdata,
  // [0] operation
  input  logic              s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [3:0] kernel_number, [39:4] projection
  output logic [39:0]       m_axis_tdata,
  output logic              m_axis_tlast,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  // Input field unpacking
  logic [FIELD_IDX_W-1:0]   in_kidx;
  logic [FIELD_IDX_W-1:0]   in_tidx;
  logic signed [COEF_W-1:0] in_coef;
  logic signed [PIX_W-1:0]  in_pixel;

  assign in_kidx  = s_axis_tdata[3:0];
  assign in_tidx  = s_axis_tdata[7:4];
  assign in_coef  = s_axis_tdata[23:8];
  assign in_pixel = s_axis_tdata[39:24];

  logic s_acc;
  logic m_acc;
  logic coef_wr;
  logic pix_in;

  // Control state
  logic [CFG_W-1:0]         kernel_count;
  logic [TAP_W-1:0]         tap_pos;
  logic                     p_valid;
  logic                     p_last;
  logic [TAP_W-1:0]         p_tap;
  logic signed [PIX_W-1:0]  p_pixel;
  logic                     m_valid;
  logic                     m_last;
  logic                     drain;
  logic [KSEL_W-1:0]        out_num;
  logic [CNT_W-1:0]         used_r;
  logic [CNT_W-1:0]         used;

  assign s_axis_tready = !drain && !(p_valid && p_last) && !(m_valid && m_last);
  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign m_acc   = m_axis_tvalid && m_axis_tready;
  assign pix_in  = s_acc && (s_axis_tuser == OP_PIXEL);
  // Writes outside the bank are dropped.
  assign coef_wr = s_acc && (s_axis_tuser == OP_COEF) &&
                   (int'(in_kidx) < KERNEL_COUNT) && (int'(in_tidx) < WINDOW_TAPS);

  // Clamp kernel_count into 1..bank size.
  always_comb begin
    if (kernel_count == '0) begin
      used = CNT_W'(1);
    end else if (int'(kernel_count) > KERNEL_COUNT) begin
      used = CNT_W'(KERNEL_COUNT);
    end else begin
      used = CNT_W'(kernel_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_count <= CFG_W'(KERNEL_COUNT);
    end else if (cfg_we) begin
      kernel_count <= cfg_wdata;
    end
  end

  // Pixel stage and tap counter
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_pos <= '0;
      p_valid <= 1'b0;
      p_last  <= 1'b0;
    end else begin
      p_valid <= pix_in;
      p_last  <= pix_in && (int'(tap_pos) == WINDOW_TAPS - 1);
      if (pix_in) begin
        tap_pos <= (int'(tap_pos) == WINDOW_TAPS - 1) ? '0 : tap_pos + TAP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_in) begin
      p_tap   <= tap_pos;
      p_pixel <= in_pixel;
    end
  end

  // Product stage marker (products live in the cells)
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      m_last  <= 1'b0;
    end else begin
      m_valid <= p_valid;
      m_last  <= p_valid && p_last;
    end
  end

  // Drain sequencer: window sums leave one per accepted output item.
  always_ff @(posedge clk) begin
    if (rst) begin
      drain   <= 1'b0;
      out_num <= '0;
      used_r  <= CNT_W'(1);
    end else if (m_valid && m_last) begin
      drain   <= 1'b1;
      out_num <= '0;
      used_r  <= used;
    end else if (m_acc) begin
      if (m_axis_tlast) begin
        drain <= 1'b0;
      end
      out_num <= out_num + KSEL_W'(1);
    end
  end

  // Cell row
  cell_ctl_t ctl;
  logic signed [ACC_W-1:0] chain [KERNEL_COUNT+1];

  always_comb begin
    ctl.wr      = coef_wr;
    ctl.wr_tap  = TAP_W'(in_tidx);
    ctl.wr_coef = in_coef;
    ctl.p_valid = p_valid;
    ctl.p_tap   = p_tap;
    ctl.p_pixel = p_pixel;
    ctl.m_valid = m_valid;
    ctl.m_last  = m_last;
    ctl.shift   = m_acc;
  end

  assign chain[KERNEL_COUNT] = '0;

  for (genvar k = 0; k < KERNEL_COUNT; k++) begin : g_cell
    logic wr_sel;
    assign wr_sel = (int'(in_kidx) == k);
    mkwp_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .wr_sel    (wr_sel),
      .shift_in  (chain[k+1]),
      .shift_out (chain[k])
    );
  end

  assign m_axis_tvalid = drain;
  assign m_axis_tdata  = {chain[0], FIELD_IDX_W'(out_num)};
  assign m_axis_tlast  = (CNT_W'(out_num) + CNT_W'(1)) == used_r;

endmodule

>>> rtl/core/mkwp_cell.sv
// One kernel cell: tap store, registered product, saturating accumulator, output shift stage.
module mkwp_cell
  import mkwp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cell_ctl_t               ctl,
  input  logic                    wr_sel,
  input  logic signed [ACC_W-1:0] shift_in,
  output logic signed [ACC_W-1:0] shift_out
);

  logic signed [COEF_W-1:0] coef_mem [WINDOW_TAPS];
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [ACC_W:0]    sum_wide;
  logic signed [ACC_W-1:0]  hold;

  // Tap store, no reset: entries are written before use.
  always_ff @(posedge clk) begin
    if (ctl.wr && wr_sel) begin
      coef_mem[ctl.wr_tap] <= ctl.wr_coef;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.p_valid) begin
      prod <= coef_mem[ctl.p_tap] * ctl.p_pixel;
    end
  end

  // Saturate to the signed accumulator range.
  always_comb begin
    sum_wide = {acc[ACC_W-1], acc} + (ACC_W+1)'(prod);
    if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
      acc_next = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_next = sum_wide[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.m_valid) begin
      acc <= ctl.m_last ? '0 : acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.m_valid && ctl.m_last) begin
      hold <= acc_next;
    end else if (ctl.shift) begin
      hold <= shift_in;
    end
  end

  assign shift_out = hold;

endmodule

>>> rtl/core/mkwp_checker.sv
// Port-level checker for the window projection core, bound to the top level.
`include "multi_kernel_window_projection_core_assert.svh"

module mkwp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A stalled result holds.
  `MKWP_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // No new items are taken while sums drain.
  `MKWP_ASSERT_IMP(a_no_accept_in_drain, clk, rst, m_axis_tvalid, !s_axis_tready)
  // Sums of a window come out in kernel order without gaps.
  `MKWP_ASSERT_NXT(a_kernel_order, clk, rst, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tdata[3:0] == $past(m_axis_tdata[3:0]) + 4'd1))
  // Each window starts at kernel 0.
  `MKWP_ASSERT_IMP(a_first_kernel, clk, rst, $rose(m_axis_tvalid), m_axis_tdata[3:0] == 4'd0)
  // The final sum ends the burst.
  `MKWP_ASSERT_NXT(a_last_ends, clk, rst, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid)

endmodule

bind multi_kernel_window_projection_core mkwp_checker u_mkwp_checker (.*);
